/* design/hrfp_pkg.sv */
`timescale 1ns / 1ps

package hrfp_pkg;

    localparam int unsigned MAX_BYTES = 65535;

    localparam int unsigned POS_W  = 16;
    localparam int unsigned COL_W  = 5;
    localparam int unsigned LEN_W  = 32;

    localparam logic [POS_W-1:0] URL_START_GET  = 16'd4;
    localparam logic [POS_W-1:0] URL_START_POST = 16'd5;
    localparam logic [POS_W-1:0] COUNT_MAX      = 16'hFFFF;

    localparam logic [COL_W-1:0] COL_KEY   = 5'd13;
    localparam logic [COL_W-1:0] COL_VALUE = 5'd16;
    localparam logic [COL_W-1:0] COL_MAX   = 5'd31;

    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_UPPER_C  = 8'h43;
    localparam logic [7:0] CH_LOWER_C  = 8'h63;
    localparam logic [7:0] CH_LOWER_H  = 8'h68;
    localparam logic [7:0] CH_UPPER_G  = 8'h47;
    localparam logic [7:0] CH_UPPER_P  = 8'h50;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    localparam int unsigned M_DATA_W = 104;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } len_phase_t;

    typedef enum logic [1:0] {
        METHOD_NONE = 2'd0,
        METHOD_GET  = 2'd1,
        METHOD_POST = 2'd2
    } method_t;

    typedef enum logic [1:0] {
        ST_BAD        = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_COMPLETE   = 2'd2,
        ST_TOO_LONG   = 2'd3
    } status_t;

    // content-length decoder view after the current byte
    typedef struct packed {
        logic             found;
        logic [LEN_W-1:0] value;
    } line_res_t;

endpackage

/* design/http_request_frame_parser_unit.sv */
`timescale 1ns / 1ps
// HTTP request frame parser.
// Input stream: one request byte per transaction on s_tdata. s_tuser[0]
// marks the first byte of a new request (all tracking state clears first),
// s_tuser[1] asks for a status result once this byte has been taken in.
// Output stream: one result transaction per byte that carried the report
// flag; bytes without it produce nothing.
// Throughput: one byte per cycle unless a result waits on a stalled
// receiver. Each byte updates the parse registers in the cycle it is
// accepted; the result lands in the output register at that same edge, so
// m_tvalid rises in the cycle after the requesting byte. The path is the
// content-length multiply by ten feeding the completion compare.
// A stalled receiver holds the result in the output register; s_tready
// stays high while that register is empty or being drained this cycle, so
// no byte is taken in while a result waits on a stalled receiver.
// Reset (aresetn low, synchronous) clears all parse state and the output
// valid flag; bytes sent before the first start flag count from offset zero.
// Requests longer than MAX_BYTES bytes stop parsing and report too long.
module http_request_frame_parser_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // data_byte
    input  logic [1:0]                     s_tuser,  // start_request, report
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0], method_kind[3:2], url_length[19:4], has_params[20],
    // params_offset[36:21], length_found[37], content_length[69:38],
    // body_seen[70], body_offset[86:71], bytes_received[102:87], zero pad
    output logic [hrfp_pkg::M_DATA_W-1:0]  m_tdata
);
    import hrfp_pkg::*;

    logic             accept, clr, take;
    logic [7:0]       b;

    logic [POS_W-1:0] pos_reg, pos_next;
    method_t          method_reg, method_next;
    logic             url_end_reg, url_end_next;
    logic [POS_W-1:0] url_len_reg, url_len_next;
    logic             query_reg, query_next;
    logic [POS_W-1:0] qoff_reg, qoff_next;
    logic             brace_reg, brace_next;
    logic [POS_W-1:0] boff_reg, boff_next;
    logic             ovf_reg, ovf_next;

    line_res_t        line_res;
    status_t          status;
    logic [POS_W-1:0] body_bytes;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    assign accept   = s_tvalid && s_tready;
    assign clr      = accept && s_tuser[0];
    assign b        = s_tdata;
    assign s_tready = !m_valid_reg || m_tready;

    always_comb begin
        logic [POS_W-1:0] ustart;
        logic             ovf_b;
        logic [POS_W-1:0] pos_b;

        ustart       = URL_START_POST;
        ovf_b        = clr ? 1'b0 : ovf_reg;
        pos_b        = clr ? '0 : pos_reg;
        method_next  = clr ? METHOD_NONE : method_reg;
        url_end_next = clr ? 1'b0 : url_end_reg;
        url_len_next = clr ? '0 : url_len_reg;
        query_next   = clr ? 1'b0 : query_reg;
        qoff_next    = clr ? '0 : qoff_reg;
        brace_next   = clr ? 1'b0 : brace_reg;
        boff_next    = clr ? '0 : boff_reg;

        take     = accept && !ovf_b && (32'(pos_b) < MAX_BYTES);
        ovf_next = ovf_b || (accept && !ovf_b && (32'(pos_b) >= MAX_BYTES));
        pos_next = take ? pos_b + 1'b1 : pos_b;

        if (take) begin
            if (pos_b == '0) begin
                if (b == CH_UPPER_G)      method_next = METHOD_GET;
                else if (b == CH_UPPER_P) method_next = METHOD_POST;
                else                      method_next = METHOD_NONE;
            end
            ustart = (method_next == METHOD_GET) ? URL_START_GET : URL_START_POST;
            if (method_next != METHOD_NONE && !url_end_next && pos_b >= ustart) begin
                if (b == CH_SPACE) begin
                    url_end_next = 1'b1;
                end else begin
                    if (url_len_next != COUNT_MAX) url_len_next = url_len_next + 1'b1;
                    if (b == CH_QUESTION && !query_next) begin
                        query_next = 1'b1;
                        qoff_next  = pos_b + 1'b1;
                    end
                end
            end
            if (b == CH_LBRACE && !brace_next) begin
                brace_next = 1'b1;
                boff_next  = pos_b;
            end
        end
    end

    hrfp_line_dec u_line (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (clr),
        .take      (take),
        .data_byte (b),
        .res       (line_res)
    );

    assign body_bytes = pos_next - boff_next;

    always_comb begin
        if (ovf_next) begin
            status = ST_TOO_LONG;
        end else if (method_next == METHOD_NONE || !url_end_next) begin
            status = ST_BAD;
        end else if (method_next == METHOD_GET) begin
            status = ST_COMPLETE;
        end else if (!line_res.found) begin
            status = ST_INCOMPLETE;
        end else if (line_res.value == '0) begin
            status = ST_COMPLETE;
        end else if (brace_next && (LEN_W'(body_bytes) >= line_res.value)) begin
            status = ST_COMPLETE;
        end else begin
            status = ST_INCOMPLETE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            method_reg  <= METHOD_NONE;
            url_end_reg <= 1'b0;
            url_len_reg <= '0;
            query_reg   <= 1'b0;
            qoff_reg    <= '0;
            brace_reg   <= 1'b0;
            boff_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            method_reg  <= method_next;
            url_end_reg <= url_end_next;
            url_len_reg <= url_len_next;
            query_reg   <= query_next;
            qoff_reg    <= qoff_next;
            brace_reg   <= brace_next;
            boff_reg    <= boff_next;
            ovf_reg     <= ovf_next;
            if (accept && s_tuser[1]) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tuser[1]) begin
            m_data_reg <= {1'b0, pos_next, boff_next, brace_next, line_res.value,
                           line_res.found, qoff_next, query_next, url_len_next,
                           method_next, status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* design/hrfp_line_dec.sv */
`timescale 1ns / 1ps

module hrfp_line_dec (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              take,
    input  logic [7:0]        data_byte,
    output hrfp_pkg::line_res_t res
);
    import hrfp_pkg::*;

    logic             nl_seen_reg, nl_seen_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             cand_reg, cand_next;
    len_phase_t       phase_reg, phase_next;
    logic [LEN_W-1:0] value_reg, value_next;

    logic             is_digit;
    logic [3:0]       digit;
    logic [LEN_W+3:0] prod;

    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign digit    = 4'(data_byte - CH_ZERO);
    // value * 10 + digit as shift-add
    assign prod = ({4'b0, value_reg} << 3) + ({4'b0, value_reg} << 1) + (LEN_W+4)'(digit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nl_seen_reg <= 1'b0;
            col_reg     <= '0;
            cand_reg    <= 1'b0;
            phase_reg   <= PH_SEARCH;
            value_reg   <= '0;
        end else begin
            nl_seen_reg <= nl_seen_next;
            col_reg     <= col_next;
            cand_reg    <= cand_next;
            phase_reg   <= phase_next;
            value_reg   <= value_next;
        end
    end

    always_comb begin
        logic [LEN_W+3:0] prod_b;
        prod_b = clear ? (LEN_W+4)'(digit) : prod;
        if (clear) begin
            nl_seen_next = 1'b0;
            col_next     = '0;
            cand_next    = 1'b0;
            phase_next   = PH_SEARCH;
            value_next   = '0;
        end else begin
            nl_seen_next = nl_seen_reg;
            col_next     = col_reg;
            cand_next    = cand_reg;
            phase_next   = phase_reg;
            value_next   = value_reg;
        end

        if (take) begin
            if (data_byte == CH_NEWLINE) begin
                if (phase_next == PH_SKIP || phase_next == PH_DIGITS) begin
                    phase_next = PH_DONE;
                end
                nl_seen_next = 1'b1;
                col_next     = '0;
                cand_next    = 1'b0;
            end else if (nl_seen_next) begin
                if (col_next == '0) begin
                    cand_next = (data_byte == CH_UPPER_C) || (data_byte == CH_LOWER_C);
                end
                if (col_next == COL_KEY && data_byte != CH_LOWER_H) begin
                    cand_next = 1'b0;
                end
                if (phase_next == PH_SEARCH && col_next == COL_VALUE && cand_next) begin
                    phase_next = PH_SKIP;
                end
                unique case (phase_next)
                    PH_SKIP: begin
                        if (is_digit) begin
                            phase_next = PH_DIGITS;
                            value_next = LEN_W'(digit);
                        end else if (data_byte != CH_SPACE) begin
                            phase_next = PH_DONE;
                            value_next = '0;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            value_next = (prod_b[LEN_W+3:LEN_W] != 4'd0) ? {LEN_W{1'b1}}
                                                                          : prod_b[LEN_W-1:0];
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                    default: ;
                endcase
                if (col_next < COL_MAX) col_next = col_next + 1'b1;
            end
        end
    end

    assign res.found = (phase_next == PH_DONE);
    assign res.value = value_next;

endmodule

/* design/hrfp_checker.sv */
`timescale 1ns / 1ps

module hrfp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [1:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hrfp_pkg::M_DATA_W-1:0] m_tdata
);
    import hrfp_pkg::*;

    // output register empty means the input side is always open
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output register");

    // a report byte always yields a result next cycle
    a_report_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[1]) |=> m_tvalid)
        else $error("report transaction produced no result");

    // a byte without report never invents a result
    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser[1] && (!m_tvalid || m_tready)) |=> !m_tvalid)
        else $error("result without report request");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // a fresh request's first byte counts as one byte received
    a_start_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] && s_tuser[1])
            |=> (m_tdata[102:87] == 16'd1))
        else $error("bytes_received wrong after start");

endmodule

bind http_request_frame_parser_unit hrfp_checker u_hrfp_checker (.*);
